// File: rtl/dvg_pkg.sv
package dvg_pkg;

  localparam int TABLE_ENTRIES = 16384;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int HASH_BUCKETS  = 32768;
  localparam int HASH_W        = $clog2(HASH_BUCKETS);
  localparam int KEY_W         = 27;
  localparam int EPOCH_W       = 8;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_VOXEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_EN = 3'd6;

  typedef struct packed {
    logic [15:0] max_depth;
    logic [23:0] inv_focal;
    logic [11:0] center_col_half;
    logic [11:0] center_row_half;
    logic [15:0] inv_voxel;
    logic [9:0]  grid_side;
    logic        color_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic [19:0]        z;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  hash;
  } proj_res_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              fresh;
    logic              full;
  } hash_res_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               fresh;
    logic               full;
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic [19:0]        z;
    logic [23:0]        rgb;
  } acc_req_t;

  typedef struct packed {
    logic signed [27:0] sx;
    logic signed [27:0] sy;
    logic [28:0]        sz;
    logic [7:0]         cnt;
    logic [23:0]        rgb;
  } acc_res_t;

  typedef struct packed {
    logic signed [20:0] mx;
    logic signed [20:0] my;
    logic [19:0]        mz;
  } div_res_t;

endpackage

// File: rtl/depth_voxel_grid_downsampler_unit.sv
// Depth pixels come in one at a time; a pixel with zero depth or depth above
// max_depth gives no result, every other pixel gives exactly one. Most of an
// item's time goes to the 30-step shift-subtract divider forming the three
// centroid means, the rest to the 8-stage back-projection chain and to one
// more hash probe on each collision. The next pixel is taken once the previous
// result sits in the output register. After reset all 32768 buckets are
// swept clean before the first pixel is taken; frame starts only bump a frame
// tag and restart slot allocation, and every 255th frame start repeats that
// sweep before the pixel is handled.
module depth_voxel_grid_downsampler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dvg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_frame_start,
  input  logic [15:0]                   in_depth_mm,
  input  logic [9:0]                    in_pixel_col,
  input  logic [9:0]                    in_pixel_row,
  input  logic [7:0]                    in_red_in,
  input  logic [7:0]                    in_green_in,
  input  logic [7:0]                    in_blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [13:0]                   out_slot,
  output logic                          out_new_voxel,
  output logic [26:0]                   out_voxel_key,
  output logic signed [20:0]            out_mean_x,
  output logic signed [20:0]            out_mean_y,
  output logic [19:0]                   out_mean_z,
  output logic [7:0]                    out_point_count,
  output logic [7:0]                    out_red_out,
  output logic [7:0]                    out_green_out,
  output logic [7:0]                    out_blue_out,
  output logic                          out_table_full
);
  import dvg_pkg::*;

  localparam logic [2:0] T_IDLE     = 3'd0;
  localparam logic [2:0] T_PROJ     = 3'd1;
  localparam logic [2:0] T_LOOK_REQ = 3'd2;
  localparam logic [2:0] T_LOOK     = 3'd3;
  localparam logic [2:0] T_ACC      = 3'd4;
  localparam logic [2:0] T_DIV      = 3'd5;
  localparam logic [2:0] T_OUT      = 3'd6;

  cfg_t cfg_r, cfg_nxt;
  logic [2:0] st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [15:0] depth_r;
  logic [9:0]  col_r, row_r;
  logic [23:0] rgb_r;

  logic in_xfer, drop, out_load;
  logic proj_done, hash_busy, hash_done, acc_done, div_done;
  logic lookup, acc_start, div_start;
  proj_res_t proj_res;
  hash_res_t hash_res;
  acc_req_t  acc_req;
  acc_res_t  acc_res;
  div_res_t  div_res;

  logic [13:0]        slot_r;
  logic               new_voxel_r, full_r;
  logic [26:0]        key_r;
  logic signed [20:0] mx_r, my_r;
  logic [19:0]        mz_r;
  logic [7:0]         cnt_r;
  logic [23:0]        color_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == T_IDLE) && !hash_busy;
  assign in_xfer   = in_valid && in_ready;
  assign drop      = (in_depth_mm == 16'd0) || (in_depth_mm > cfg_r.max_depth);
  assign lookup    = (st_r == T_LOOK_REQ) && !hash_busy;
  assign acc_start = (st_r == T_LOOK) && hash_done;
  assign div_start = (st_r == T_ACC) && acc_done;
  assign out_load  = (st_r == T_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_DEPTH:  cfg_nxt.max_depth       = cfg_data[15:0];
        CFG_INV_FOCAL:  cfg_nxt.inv_focal       = cfg_data;
        CFG_CENTER_COL: cfg_nxt.center_col_half = cfg_data[11:0];
        CFG_CENTER_ROW: cfg_nxt.center_row_half = cfg_data[11:0];
        CFG_INV_VOXEL:  cfg_nxt.inv_voxel       = cfg_data[15:0];
        CFG_GRID_SIDE:  cfg_nxt.grid_side       = cfg_data[9:0];
        CFG_COLOR_EN:   cfg_nxt.color_enable    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE:     if (in_xfer && !drop) st_nxt = T_PROJ;
      T_PROJ:     if (proj_done) st_nxt = T_LOOK_REQ;
      T_LOOK_REQ: if (lookup) st_nxt = T_LOOK;
      T_LOOK:     if (hash_done) st_nxt = T_ACC;
      T_ACC:      if (acc_done) st_nxt = T_DIV;
      T_DIV:      if (div_done) st_nxt = T_OUT;
      T_OUT:      if (out_load) st_nxt = T_IDLE;
      default:    st_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{max_depth: 16'd3500, inv_focal: 24'd31957, center_col_half: 12'd639,
                       center_row_half: 12'd479, inv_voxel: 16'd6554, grid_side: 10'd600,
                       color_enable: 1'b1};
      st_r        <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      depth_r <= in_depth_mm;
      col_r   <= in_pixel_col;
      row_r   <= in_pixel_row;
      rgb_r   <= {in_red_in, in_green_in, in_blue_in};
    end
    if (out_load) begin
      slot_r      <= hash_res.slot;
      new_voxel_r <= hash_res.fresh;
      full_r      <= hash_res.full;
      key_r       <= proj_res.key;
      mx_r        <= div_res.mx;
      my_r        <= div_res.my;
      mz_r        <= div_res.mz;
      cnt_r       <= acc_res.cnt;
      color_r     <= acc_res.rgb;
    end
  end

  assign acc_req = '{slot: hash_res.slot, fresh: hash_res.fresh, full: hash_res.full,
                     x: proj_res.x, y: proj_res.y, z: proj_res.z,
                     rgb: cfg_r.color_enable ? rgb_r : 24'd0};

  dvg_project u_project (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer && !drop),
    .cfg   (cfg_r),
    .depth (depth_r),
    .col   (col_r),
    .row   (row_r),
    .done  (proj_done),
    .res   (proj_res)
  );

  dvg_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .frame  (in_xfer && in_frame_start),
    .lookup (lookup),
    .key    (proj_res.key),
    .hash   (proj_res.hash),
    .busy   (hash_busy),
    .done   (hash_done),
    .res    (hash_res)
  );

  dvg_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc_start),
    .req   (acc_req),
    .done  (acc_done),
    .res   (acc_res)
  );

  dvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .acc   (acc_res),
    .done  (div_done),
    .res   (div_res)
  );

  assign out_valid       = out_valid_r;
  assign out_slot        = slot_r;
  assign out_new_voxel   = new_voxel_r;
  assign out_voxel_key   = key_r;
  assign out_mean_x      = mx_r;
  assign out_mean_y      = my_r;
  assign out_mean_z      = mz_r;
  assign out_point_count = cnt_r;
  assign out_red_out     = color_r[23:16];
  assign out_green_out   = color_r[15:8];
  assign out_blue_out    = color_r[7:0];
  assign out_table_full  = full_r;

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      (out_slot == 14'd0 && !out_new_voxel && out_point_count == 8'd1))
    else $error("table full result with stored voxel fields");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_count != 8'd0))
    else $error("result with zero point count");
  a_proj_done: assert property (@(posedge clk) disable iff (!rst_n)
    proj_done |-> (st_r == T_PROJ))
    else $error("projection finished while not awaited");
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    acc_done |-> (st_r == T_ACC))
    else $error("accumulate finished while not awaited");

endmodule

// File: rtl/dvg_project.sv
module dvg_project (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  dvg_pkg::cfg_t      cfg,
  input  logic [15:0]        depth,
  input  logic [9:0]         col,
  input  logic [9:0]         row,
  output logic               done,
  output dvg_pkg::proj_res_t res
);
  import dvg_pkg::*;

  localparam logic [3:0] PROJ_STEPS = 4'd8;

  logic [3:0] step_r, step_nxt;
  logic       done_r, done_nxt;

  logic signed [28:0] pdx_r, pdy_r;
  logic signed [52:0] px_r, py_r;
  logic signed [20:0] x_r, y_r;
  logic [19:0]        z_r;
  logic signed [37:0] tx_r, ty_r;
  logic [35:0]        tz_r;
  logic [9:0]         ix_r, iy_r;
  logic [15:0]        iz_r;
  logic [19:0]        iys_r;
  logic [25:0]        izs_r;
  logic [KEY_W-1:0]   key_r;
  logic [HASH_W-1:0]  hash_r;

  logic [11:0]        col2, row2;
  logic signed [28:0] dc, dr, dep29;
  logic signed [52:0] foc53;
  logic signed [37:0] vox38, side38;
  logic [9:0]         top;
  logic [35:0]        izss;
  logic [HASH_W-1:0]  hprod;

  function automatic logic signed [20:0] bp_sat(input logic signed [52:0] p);
    logic signed [53:0] t;
    logic signed [53:0] sh;
    logic signed [32:0] f;
    t  = $signed(54'd1048576) - $signed({p[52], p});
    sh = t >>> 21;
    f  = sh[32:0];
    if (f > 33'sd1048575) return 21'sd1048575;
    if (f < -33'sd1048576) return -21'sd1048576;
    return f[20:0];
  endfunction

  function automatic logic [9:0] gidx(input logic signed [37:0] t, input logic [9:0] lim);
    logic [16:0] q;
    q = t[36:20];
    if (t[37]) return '0;
    if (q > {7'd0, lim}) return lim;
    return q[9:0];
  endfunction

  assign col2  = {({1'b0, col} + 11'd1), 1'b0};
  assign row2  = {({1'b0, row} + 11'd1), 1'b0};
  assign dc    = $signed({17'd0, col2}) - $signed({17'd0, cfg.center_col_half});
  assign dr    = $signed({17'd0, row2}) - $signed({17'd0, cfg.center_row_half});
  assign dep29 = $signed({13'd0, depth});
  assign foc53 = $signed({29'd0, cfg.inv_focal});
  assign vox38 = $signed({22'd0, cfg.inv_voxel});
  assign side38 = $signed({9'd0, cfg.grid_side, 19'd0});
  assign top   = (cfg.grid_side == 10'd0) ? 10'd0 : cfg.grid_side - 10'd1;
  assign izss  = {10'd0, izs_r} * {26'd0, cfg.grid_side};
  assign hprod = key_r[HASH_W-1:0] * HASH_MULT[HASH_W-1:0];

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (step_r == '0) begin
      if (start) step_nxt = 4'd1;
    end else if (step_r == PROJ_STEPS) begin
      step_nxt = '0;
      done_nxt = 1'b1;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  // pixel operands stay put for the whole item, so the chain settles one stage a cycle
  always_ff @(posedge clk) begin
    pdx_r  <= dc * dep29;
    pdy_r  <= dr * dep29;
    px_r   <= $signed({{24{pdx_r[28]}}, pdx_r}) * foc53;
    py_r   <= $signed({{24{pdy_r[28]}}, pdy_r}) * foc53;
    x_r    <= bp_sat(px_r);
    y_r    <= bp_sat(py_r);
    z_r    <= {depth, 4'd0};
    tx_r   <= $signed({{17{x_r[20]}}, x_r}) * vox38 + side38;
    ty_r   <= $signed({{17{y_r[20]}}, y_r}) * vox38 + side38;
    tz_r   <= {16'd0, z_r} * {20'd0, cfg.inv_voxel};
    ix_r   <= gidx(tx_r, top);
    iy_r   <= gidx(ty_r, top);
    iz_r   <= tz_r[35:20];
    iys_r  <= {10'd0, iy_r} * {10'd0, cfg.grid_side};
    izs_r  <= {10'd0, iz_r} * {16'd0, cfg.grid_side};
    key_r  <= {17'd0, ix_r} + {7'd0, iys_r} + izss[KEY_W-1:0];
    hash_r <= hprod;
  end

  assign done     = done_r;
  assign res.x    = x_r;
  assign res.y    = y_r;
  assign res.z    = z_r;
  assign res.key  = key_r;
  assign res.hash = hash_r;

endmodule

// File: rtl/dvg_hash.sv
module dvg_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       frame,
  input  logic                       lookup,
  input  logic [dvg_pkg::KEY_W-1:0]  key,
  input  logic [dvg_pkg::HASH_W-1:0] hash,
  output logic                       busy,
  output logic                       done,
  output dvg_pkg::hash_res_t         res
);
  import dvg_pkg::*;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
  } bkt_t;

  localparam logic [1:0] H_CLEAR = 2'd0;
  localparam logic [1:0] H_IDLE  = 2'd1;
  localparam logic [1:0] H_PROBE = 2'd2;

  bkt_t mem [HASH_BUCKETS];
  bkt_t rd_q, wr_data;
  logic [HASH_W-1:0] rd_addr, wr_addr;
  logic              wr_en;

  logic [1:0]         st_r, st_nxt;
  logic [HASH_W-1:0]  probe_r, probe_nxt;
  logic [HASH_W-1:0]  clr_r, clr_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [SLOT_W:0]    next_slot_r, next_slot_nxt;
  logic               done_r, done_nxt;
  hash_res_t          res_r, res_nxt;

  always_comb begin
    st_nxt        = st_r;
    probe_nxt     = probe_r;
    clr_nxt       = clr_r;
    key_nxt       = key_r;
    epoch_nxt     = epoch_r;
    next_slot_nxt = next_slot_r;
    done_nxt      = 1'b0;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = probe_r;
    wr_data       = '{epoch: epoch_r, key: key_r, slot: next_slot_r[SLOT_W-1:0]};
    rd_addr       = probe_r + 1'b1;
    unique case (st_r)
      H_CLEAR: begin
        // epoch zero never matches a live epoch
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) st_nxt = H_IDLE;
      end
      H_IDLE: begin
        rd_addr = hash;
        if (frame) begin
          next_slot_nxt = '0;
          if (&epoch_r) begin
            epoch_nxt = EPOCH_W'(1);
            st_nxt    = H_CLEAR;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end else if (lookup) begin
          probe_nxt = hash;
          key_nxt   = key;
          st_nxt    = H_PROBE;
        end
      end
      H_PROBE: begin
        if (rd_q.epoch != epoch_r) begin
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
          if (next_slot_r >= (SLOT_W+1)'(TABLE_ENTRIES)) begin
            res_nxt = '{slot: '0, fresh: 1'b0, full: 1'b1};
          end else begin
            wr_en         = 1'b1;
            res_nxt       = '{slot: next_slot_r[SLOT_W-1:0], fresh: 1'b1, full: 1'b0};
            next_slot_nxt = next_slot_r + 1'b1;
          end
        end else if (rd_q.key == key_r) begin
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
          res_nxt  = '{slot: rd_q.slot, fresh: 1'b0, full: 1'b0};
        end else begin
          // advance to the next bucket, its read is issued now
          probe_nxt = probe_r + 1'b1;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= H_CLEAR;
      clr_r       <= '0;
      epoch_r     <= EPOCH_W'(1);
      next_slot_r <= '0;
      done_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      epoch_r     <= epoch_nxt;
      next_slot_r <= next_slot_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    key_r   <= key_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign busy = (st_r != H_IDLE);
  assign done = done_r;
  assign res  = res_r;

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_slot_r <= (SLOT_W+1)'(TABLE_ENTRIES))
    else $error("slot counter past table size");
  a_fresh_full: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !(res_r.fresh && res_r.full))
    else $error("lookup both fresh and full");
  a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (frame || lookup) |-> (st_r == H_IDLE))
    else $error("command while table busy");
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && res_r.fresh) |-> (next_slot_r == $past(next_slot_r) + 1'b1))
    else $error("new voxel without slot allocation");

endmodule

// File: rtl/dvg_accum.sv
module dvg_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dvg_pkg::acc_req_t req,
  output logic              done,
  output dvg_pkg::acc_res_t res
);
  import dvg_pkg::*;

  acc_res_t mem [TABLE_ENTRIES];
  acc_res_t rd_q, upd, own;
  logic     wr_en;

  logic upd_r;
  logic done_r;
  acc_res_t res_r;

  logic signed [28:0] sx29, sy29;
  logic signed [27:0] sxs, sys;
  logic [29:0]        sz30;
  logic [28:0]        szs;

  assign sx29 = $signed({rd_q.sx[27], rd_q.sx}) + $signed({{8{req.x[20]}}, req.x});
  assign sy29 = $signed({rd_q.sy[27], rd_q.sy}) + $signed({{8{req.y[20]}}, req.y});
  assign sz30 = {1'b0, rd_q.sz} + {10'd0, req.z};
  assign sxs  = (sx29 > 29'sd134217727) ? 28'sd134217727 :
                (sx29 < -29'sd134217728) ? -28'sd134217728 : sx29[27:0];
  assign sys  = (sy29 > 29'sd134217727) ? 28'sd134217727 :
                (sy29 < -29'sd134217728) ? -28'sd134217728 : sy29[27:0];
  assign szs  = sz30[29] ? '1 : sz30[28:0];

  assign own = '{sx: $signed({{7{req.x[20]}}, req.x}), sy: $signed({{7{req.y[20]}}, req.y}),
                 sz: {9'd0, req.z}, cnt: 8'd1, rgb: req.rgb};

  always_comb begin
    wr_en = 1'b0;
    upd   = rd_q;
    if (req.full) begin
      upd = own;
    end else if (req.fresh) begin
      upd   = own;
      wr_en = upd_r;
    end else if (rd_q.cnt != 8'd255) begin
      upd   = '{sx: sxs, sy: sys, sz: szs, cnt: rd_q.cnt + 8'd1, rgb: rd_q.rgb};
      wr_en = upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      upd_r  <= start;
      done_r <= upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_r) res_r <= upd;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[req.slot] <= upd;
    rd_q <= mem[req.slot];
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: rtl/dvg_div.sv
module dvg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dvg_pkg::acc_res_t acc,
  output logic              done,
  output dvg_pkg::div_res_t res
);
  import dvg_pkg::*;

  localparam int LANES   = 3;
  localparam int DIV_W   = 30;
  localparam logic [4:0] LAST_STEP = 5'(DIV_W - 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]       st_r;
  logic [4:0]       cyc_r;
  logic             done_r;
  logic [DIV_W-1:0] dq_r  [LANES];
  logic [7:0]       rem_r [LANES];
  logic [LANES-1:0] neg_r;
  logic [7:0]       cnt_r;
  div_res_t         res_r;

  logic [DIV_W-1:0] dq_nxt  [LANES];
  logic [7:0]       rem_nxt [LANES];
  logic [8:0]       trial   [LANES];
  logic [27:0]      absx, absy;

  function automatic logic signed [20:0] sat_s21(input logic [DIV_W-1:0] q, input logic neg);
    logic [DIV_W-1:0] nq;
    nq = -q;
    if (neg) begin
      if (q > DIV_W'(1048576)) return -21'sd1048576;
      return $signed(nq[20:0]);
    end
    if (q > DIV_W'(1048575)) return 21'sd1048575;
    return $signed(q[20:0]);
  endfunction

  assign absx = acc.sx[27] ? (~acc.sx + 28'd1) : acc.sx;
  assign absy = acc.sy[27] ? (~acc.sy + 28'd1) : acc.sy;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {rem_r[i], dq_r[i][DIV_W-1]};
      if (trial[i] >= {1'b0, cnt_r}) begin
        rem_nxt[i] = 8'(trial[i] - {1'b0, cnt_r});
        dq_nxt[i]  = {dq_r[i][DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[i][7:0];
        dq_nxt[i]  = {dq_r[i][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      cyc_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          cyc_r <= '0;
          if (start) st_r <= D_RUN;
        end
        D_RUN: begin
          cyc_r <= cyc_r + 5'd1;
          if (cyc_r == LAST_STEP) st_r <= D_FIN;
        end
        D_FIN: begin
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  // magnitudes carry half the divisor so truncation rounds halves away from zero
  always_ff @(posedge clk) begin
    if (st_r == D_IDLE && start) begin
      dq_r[0]  <= {2'd0, absx} + {23'd0, acc.cnt[7:1]};
      dq_r[1]  <= {2'd0, absy} + {23'd0, acc.cnt[7:1]};
      dq_r[2]  <= {1'b0, acc.sz} + {23'd0, acc.cnt[7:1]};
      rem_r[0] <= '0;
      rem_r[1] <= '0;
      rem_r[2] <= '0;
      neg_r    <= {1'b0, acc.sy[27], acc.sx[27]};
      cnt_r    <= acc.cnt;
    end else if (st_r == D_RUN) begin
      for (int i = 0; i < LANES; i++) begin
        dq_r[i]  <= dq_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
    if (st_r == D_FIN) begin
      res_r.mx <= sat_s21(dq_r[0], neg_r[0]);
      res_r.my <= sat_s21(dq_r[1], neg_r[1]);
      res_r.mz <= (dq_r[2] > DIV_W'(1048575)) ? 20'hFFFFF : dq_r[2][19:0];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
